[src/kinematic_surface_velocity_unit_assert.svh]
// Assertion macros for the kinematic surface velocity unit.
// Used by the top level; needs clk_i and rst_ni in the enclosing module.
`ifndef KINEMATIC_SURFACE_VELOCITY_UNIT_ASSERT_SVH
`define KINEMATIC_SURFACE_VELOCITY_UNIT_ASSERT_SVH
`ifndef SYNTH
`define KSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define KSV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define KSV_ASSERT(lbl, prop, msg)
`define KSV_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[src/ksv_pkg.sv]
// Shared types and constants of the kinematic surface velocity unit.
// No dependencies.
`default_nettype none
package ksv_pkg;

  localparam int IN_W      = 352;
  localparam int OUT_W     = 32;
  localparam int DIV_STEPS = 63;
  localparam int AXIS_LAT  = DIV_STEPS + 6;

  localparam logic [2:0] MODE_ZERO     = 3'd0;
  localparam logic [2:0] MODE_UPWIND   = 3'd1;
  localparam logic [2:0] MODE_CENTRAL  = 3'd2;
  localparam logic [2:0] MODE_LIMITED  = 3'd3;
  localparam logic [2:0] MODE_LIM_MAIN = 3'd4;
  localparam logic [2:0] RESET_MODE    = MODE_UPWIND;

  localparam logic REG_SLOPE_SCHEME = 1'b0;

  typedef enum logic [1:0] {
    KIND_UPWIND  = 2'd0,
    KIND_CENTRAL = 2'd1,
    KIND_LIMITED = 2'd2
  } kind_e;

  typedef struct packed {
    logic signed [31:0] vel;
    logic signed [31:0] dback;
    logic signed [31:0] dfwd;
    logic [30:0]        hback;
    logic [30:0]        hfwd;
  } axis_in_t;

  typedef struct packed {
    logic               write_main;
    logic               mode_zero;
    logic signed [31:0] rise;
  } meta_t;

endpackage
`default_nettype wire

[src/ksv_axis.sv]
// One axis advection term: slope selection, products and a bit-per-stage divider.
// Depends on ksv_pkg.
`default_nettype none
module ksv_axis (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire ksv_pkg::kind_e      kind_i,
  input  wire ksv_pkg::axis_in_t   data_i,
  output logic signed [63:0]       term_o
);
  import ksv_pkg::*;

  typedef struct packed {
    logic [63:0] rem;
    logic [62:0] low;
    logic [62:0] quo;
    logic [63:0] den;
    logic        ovf;
    logic        zero;
    logic        neg;
  } div_t;

  logic        vneg, bneg, fneg;
  logic [31:0] vmag, mb, mf;
  logic [32:0] csum, cmag;

  assign vneg = data_i.vel[31];
  assign bneg = data_i.dback[31];
  assign fneg = data_i.dfwd[31];
  assign vmag = vneg ? (~data_i.vel + 32'd1) : data_i.vel;
  assign mb   = bneg ? (~data_i.dback + 32'd1) : data_i.dback;
  assign mf   = fneg ? (~data_i.dfwd + 32'd1) : data_i.dfwd;
  assign csum = {data_i.dback[31], data_i.dback} + {data_i.dfwd[31], data_i.dfwd};
  assign cmag = csum[32] ? (~csum + 33'd1) : csum;

  kind_e       kind1_q;
  logic        vneg1_q, vzero1_q, fneg1_q, lim_ok1_q, up_neg1_q, cneg1_q;
  logic [31:0] vmag1_q, up_mag1_q, cden1_q;
  logic [30:0] up_den1_q;
  logic [32:0] cmag1_q;
  logic [63:0] p1_q, p2_q, p3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind1_q   <= kind_i;
      vneg1_q   <= vneg;
      vzero1_q  <= (data_i.vel == 32'sd0);
      vmag1_q   <= vmag;
      fneg1_q   <= fneg;
      lim_ok1_q <= (mb != 32'd0) && (mf != 32'd0) && (bneg == fneg);
      p1_q      <= mf * mb;
      p2_q      <= mf * {1'b0, data_i.hback};
      p3_q      <= mb * {1'b0, data_i.hfwd};
      up_mag1_q <= vneg ? mf : mb;
      up_neg1_q <= vneg ? fneg : bneg;
      up_den1_q <= vneg ? data_i.hfwd : data_i.hback;
      cmag1_q   <= cmag;
      cneg1_q   <= csum[32];
      cden1_q   <= {1'b0, data_i.hback} + {1'b0, data_i.hfwd};
    end
  end

  logic [63:0] num2_d, den2_d;
  logic        nneg2_d, kill2_d;

  always_comb begin
    num2_d  = 64'd0;
    den2_d  = 64'd0;
    nneg2_d = 1'b0;
    kill2_d = 1'b1;
    unique case (kind1_q)
      KIND_UPWIND: begin
        num2_d  = {32'd0, up_mag1_q};
        den2_d  = {33'd0, up_den1_q};
        nneg2_d = up_neg1_q;
        kill2_d = 1'b0;
      end
      KIND_CENTRAL: begin
        num2_d  = {31'd0, cmag1_q};
        den2_d  = {32'd0, cden1_q};
        nneg2_d = cneg1_q;
        kill2_d = 1'b0;
      end
      KIND_LIMITED: begin
        num2_d  = {p1_q[62:0], 1'b0};
        den2_d  = p2_q + p3_q;
        nneg2_d = fneg1_q;
        kill2_d = !lim_ok1_q;
      end
      default: begin
        kill2_d = 1'b1;
      end
    endcase
  end

  logic [63:0] num2_q, den2_q, den3_q, den4_q;
  logic [31:0] vmag2_q;
  logic        zero2_q, neg2_q, zero3_q, neg3_q, zero4_q, neg4_q;
  logic [63:0] pplo3_q, pphi3_q;
  logic [95:0] dvd4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num2_q  <= num2_d;
      den2_q  <= den2_d;
      vmag2_q <= vmag1_q;
      zero2_q <= kill2_d || vzero1_q || (num2_d == 64'd0) || (den2_d == 64'd0);
      neg2_q  <= vneg1_q ^ nneg2_d;
      pplo3_q <= num2_q[31:0] * vmag2_q;
      pphi3_q <= num2_q[63:32] * vmag2_q;
      den3_q  <= den2_q;
      zero3_q <= zero2_q;
      neg3_q  <= neg2_q;
      dvd4_q  <= {32'd0, pplo3_q} + {pphi3_q, 32'd0};
      den4_q  <= den3_q;
      zero4_q <= zero3_q;
      neg4_q  <= neg3_q;
    end
  end

  div_t div_q [0:DIV_STEPS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q[0].rem  <= {31'd0, dvd4_q[95:63]};
      div_q[0].low  <= dvd4_q[62:0];
      div_q[0].quo  <= 63'd0;
      div_q[0].den  <= den4_q;
      div_q[0].ovf  <= ({31'd0, dvd4_q[95:63]} >= den4_q);
      div_q[0].zero <= zero4_q;
      div_q[0].neg  <= neg4_q;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [64:0] sh;
    logic [64:0] diff;
    logic        ge;
    assign sh   = {div_q[k-1].rem, div_q[k-1].low[62]};
    assign diff = sh - {1'b0, div_q[k-1].den};
    assign ge   = (sh >= {1'b0, div_q[k-1].den});
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        div_q[k].rem  <= ge ? diff[63:0] : sh[63:0];
        div_q[k].low  <= {div_q[k-1].low[61:0], 1'b0};
        div_q[k].quo  <= {div_q[k-1].quo[61:0], ge};
        div_q[k].den  <= div_q[k-1].den;
        div_q[k].ovf  <= div_q[k-1].ovf;
        div_q[k].zero <= div_q[k-1].zero;
        div_q[k].neg  <= div_q[k-1].neg;
      end
    end
  end

  logic [62:0] qsat;
  logic [63:0] qmag;
  assign qsat = div_q[DIV_STEPS].ovf ? {63{1'b1}} : div_q[DIV_STEPS].quo;
  assign qmag = {1'b0, qsat};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (div_q[DIV_STEPS].zero) begin
        term_o <= 64'sd0;
      end else if (div_q[DIV_STEPS].neg) begin
        term_o <= $signed(~qmag + 64'd1);
      end else begin
        term_o <= $signed(qmag);
      end
    end
  end

endmodule
`default_nettype wire

[src/kinematic_surface_velocity_unit.sv]
// Top level of the kinematic surface velocity unit: stream ports, APB register, pipeline.
// Depends on ksv_pkg, ksv_axis and kinematic_surface_velocity_unit_assert.svh.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata: cell fields (352 bits)
//  m_axis    out  m_axis_tvalid/tready       tdata: vert_vel, tuser: write_main
//  apb       in   psel/penable/pwrite/pready slope_scheme at byte address 0
//
// One transaction per cycle while the output is not stalled; a result passes 72 register
// stages (input register, 69 stages of the axis units set by the 63-step restoring divider,
// sum and saturate stages) before it is shown on m_axis.
// Reset clears the valid bits and sets slope_scheme to upwind.
// The whole pipeline holds while the output register has a result not taken.
`default_nettype none
`include "kinematic_surface_velocity_unit_assert.svh"
module kinematic_surface_velocity_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // rise_rate, vel_x, vel_y, diff_west, diff_east, diff_south, diff_north,
  // dx_back, dx_fwd, dy_back, dy_fwd, zero pad
  input  wire logic [ksv_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // vert_vel
  output logic [ksv_pkg::OUT_W-1:0]       m_axis_tdata,
  // write_main
  output logic [0:0]                      m_axis_tuser,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import ksv_pkg::*;

  logic [2:0] mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= RESET_MODE;
    end else if (psel && penable && pwrite && (paddr[2] == REG_SLOPE_SCHEME)) begin
      mode_q <= pwdata[2:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SLOPE_SCHEME) ? {29'd0, mode_q} : 32'd0;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  kind_e    kind_d, kind_q;
  axis_in_t ax_d, ay_d, ax_q, ay_q;
  meta_t    meta_d;

  always_comb begin
    unique case (mode_q)
      MODE_UPWIND:  kind_d = KIND_UPWIND;
      MODE_CENTRAL: kind_d = KIND_CENTRAL;
      default:      kind_d = KIND_LIMITED;
    endcase
  end

  assign meta_d.rise       = $signed(s_axis_tdata[31:0]);
  assign meta_d.write_main = (mode_q == MODE_LIM_MAIN);
  assign meta_d.mode_zero  = (mode_q == MODE_ZERO);
  assign ax_d.vel   = $signed(s_axis_tdata[63:32]);
  assign ax_d.dback = $signed(s_axis_tdata[127:96]);
  assign ax_d.dfwd  = $signed(s_axis_tdata[159:128]);
  assign ax_d.hback = s_axis_tdata[254:224];
  assign ax_d.hfwd  = s_axis_tdata[285:255];
  assign ay_d.vel   = $signed(s_axis_tdata[95:64]);
  assign ay_d.dback = $signed(s_axis_tdata[191:160]);
  assign ay_d.dfwd  = $signed(s_axis_tdata[223:192]);
  assign ay_d.hback = s_axis_tdata[316:286];
  assign ay_d.hfwd  = s_axis_tdata[347:317];

  logic  vld_q  [0:AXIS_LAT];
  meta_t meta_q [0:AXIS_LAT];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q      <= ax_d;
      ay_q      <= ay_d;
      kind_q    <= kind_d;
      meta_q[0] <= meta_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid;
    end
  end

  for (genvar i = 1; i <= AXIS_LAT; i++) begin : g_meta
    always_ff @(posedge clk_i) begin
      if (en) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  logic signed [63:0] tx, ty;

  ksv_axis u_axis_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .kind_i (kind_q),
    .data_i (ax_q),
    .term_o (tx)
  );

  ksv_axis u_axis_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .kind_i (kind_q),
    .data_i (ay_q),
    .term_o (ty)
  );

  logic signed [64:0] sum_q;
  meta_t              meta_s_q;
  logic               vld_s_q;
  logic signed [65:0] tot;

  assign tot = {sum_q[64], sum_q} + {{34{meta_s_q.rise[31]}}, meta_s_q.rise};

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q    <= {tx[63], tx} + {ty[63], ty};
      meta_s_q <= meta_q[AXIS_LAT];
      if (meta_s_q.mode_zero) begin
        m_axis_tdata <= '0;
      end else if (tot > 66'sd2147483647) begin
        m_axis_tdata <= 32'h7FFF_FFFF;
      end else if (tot < -66'sd2147483648) begin
        m_axis_tdata <= 32'h8000_0000;
      end else begin
        m_axis_tdata <= tot[31:0];
      end
      m_axis_tuser <= meta_s_q.write_main;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s_q       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      vld_s_q       <= vld_q[AXIS_LAT];
      m_axis_tvalid <= vld_s_q;
    end
  end

  `KSV_ASSERT(a_ready_follows_out, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "input ready does not follow output stall")
  `KSV_ASSERT(a_mode_write_only, !(psel && penable && pwrite) |=> $stable(mode_q), "slope scheme changed without a write")
  `KSV_ASSERT(a_zero_mode_out, (en && vld_s_q && meta_s_q.mode_zero) |=> (m_axis_tdata == '0), "zero scheme gave a nonzero result")
  `KSV_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule
`default_nettype wire
